@@ rtl/core/i2p_pkg.sv @@
package i2p_pkg;

   // input token kinds
   typedef enum logic [2:0] {
      KIND_NUM    = 3'd0,
      KIND_VAR    = 3'd1,
      KIND_FUNC   = 3'd2,
      KIND_COMMA  = 3'd3,
      KIND_OP     = 3'd4,
      KIND_LPAREN = 3'd5,
      KIND_RPAREN = 3'd6,
      KIND_END    = 3'd7
   } kind_type;

   // output token kinds
   localparam logic [2:0] OUT_KIND_FUNC = 3'd2;
   localparam logic [2:0] OUT_KIND_OP   = 3'd3;
   localparam logic [2:0] OUT_KIND_END  = 3'd4;

   // end marker status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_COMMA    = 3'd1;
   localparam logic [2:0] STATUS_EMPTY    = 3'd2;
   localparam logic [2:0] STATUS_MISMATCH = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

   // stack entry tag, the payload rides beside it
   typedef struct packed {
      kind_type   kind;
      logic [3:0] prec;
   } tag_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stk_ctrl_type;

   typedef struct packed {
      logic emit;
      logic finish;
   } obuf_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DECIDE,
      ST_FUNC_WAIT,
      ST_FUNC_DECIDE,
      ST_FINISH
   } state_type;

   function automatic logic [2:0] out_kind_of(input kind_type k);
      logic [2:0] r;
      case (k)
         KIND_OP:   r = OUT_KIND_OP;
         KIND_FUNC: r = OUT_KIND_FUNC;
         default:   r = k;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/i2p_if.sv @@
interface i2p_req_if #(parameter int PAYLOAD_BITS = 16);
   logic                    valid;
   logic                    ready;
   logic [2:0]              kind;
   logic [PAYLOAD_BITS-1:0] payload;
   logic [3:0]              precedence;
   logic                    right_assoc;

   modport source (output valid, kind, payload, precedence, right_assoc, input ready);
   modport sink   (input valid, kind, payload, precedence, right_assoc, output ready);
endinterface

interface i2p_rsp_if #(parameter int PAYLOAD_BITS = 16);
   logic                    valid;
   logic                    ready;
   logic [2:0]              out_kind;
   logic [PAYLOAD_BITS-1:0] out_payload;
   logic [2:0]              status;
   logic                    last;

   modport source (output valid, out_kind, out_payload, status, last, input ready);
   modport sink   (input valid, out_kind, out_payload, status, last, output ready);
endinterface

@@ rtl/core/i2p_stack.sv @@
module i2p_stack import i2p_pkg::*; #(
   parameter int DEPTH        = 16,
   parameter int PAYLOAD_BITS = 16,
   localparam int AW          = $clog2(DEPTH),
   localparam int CW          = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stk_ctrl_type            ctrl,
   input  tag_type                 wr_tag,
   input  logic [PAYLOAD_BITS-1:0] wr_payload,
   output tag_type                 top_tag,
   output logic [PAYLOAD_BITS-1:0] top_payload,
   output logic [CW-1:0]           count,
   output logic                    full,
   output logic                    empty
);

   localparam int EW = $bits(tag_type) + PAYLOAD_BITS;

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] top_idx;
   logic [AW-1:0] top_addr;
   logic [AW-1:0] wr_addr;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign top_idx  = count_ff - CW'(1);
   assign top_addr = top_idx[AW-1:0];
   assign wr_addr  = count_ff[AW-1:0];

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.push && !full) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.pop && !empty) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // top of stack read is registered, valid in the cycle after the count settles
   always_ff @(posedge clock) begin
      if (ctrl.push && !full && !ctrl.clear) begin
         mem[wr_addr] <= {wr_tag, wr_payload};
      end
      if (!empty) begin
         rd_ff <= mem[top_addr];
      end
   end

   assign top_tag     = rd_ff[EW-1:PAYLOAD_BITS];
   assign top_payload = rd_ff[PAYLOAD_BITS-1:0];
   assign count       = count_ff;

endmodule

@@ rtl/core/i2p_outbuf.sv @@
module i2p_outbuf import i2p_pkg::*; #(
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  obuf_ctrl_type           ctrl,
   input  logic [2:0]              item_kind,
   input  logic [PAYLOAD_BITS-1:0] item_payload,
   input  logic [2:0]              item_status,
   output logic                    slot_ok,
   output logic                    pend_valid,
   i2p_rsp_if.source               rsp_chan
);

   // one pending result held back until it is known whether it is the last
   logic                    pend_valid_ff;
   logic                    pend_valid_in;
   logic [2:0]              pend_kind_ff;
   logic [PAYLOAD_BITS-1:0] pend_payload_ff;
   logic [2:0]              pend_status_ff;

   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [2:0]              out_kind_ff;
   logic [PAYLOAD_BITS-1:0] out_payload_ff;
   logic [2:0]              out_status_ff;
   logic                    out_last_ff;

   logic                    out_free;
   logic                    load_out;

   always_comb begin
      out_free      = !out_valid_ff || rsp_chan.ready;
      slot_ok       = !pend_valid_ff || out_free;
      load_out      = pend_valid_ff && out_free && (ctrl.emit || ctrl.finish);
      out_valid_in  = load_out || (out_valid_ff && !rsp_chan.ready);
      pend_valid_in = ctrl.emit || (pend_valid_ff && !load_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_kind_ff    <= pend_kind_ff;
         out_payload_ff <= pend_payload_ff;
         out_status_ff  <= pend_status_ff;
         out_last_ff    <= ctrl.finish;
      end
      if (ctrl.emit) begin
         pend_kind_ff    <= item_kind;
         pend_payload_ff <= item_payload;
         pend_status_ff  <= item_status;
      end
   end

   assign pend_valid           = pend_valid_ff;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_kind    = out_kind_ff;
   assign rsp_chan.out_payload = out_payload_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.last        = out_last_ff;

endmodule

@@ rtl/core/infix_to_postfix_converter_top.sv @@
// channel   | direction | transaction contents
// ----------+-----------+--------------------------------------------------
// req_chan  | in        | kind, payload, precedence, right_assoc (one token)
// rsp_chan  | out       | out_kind, out_payload, status, last (one token)
//
// a token passes idle, dispatch and finish; each token the pop loop emits adds
// a decide and a dispatch, a stop on a nonempty stack adds a decide, and a right
// paren dropping its left paren over other entries adds a func wait and decide
// the stack top read is registered, so each loop pass is a dispatch and a decide
// reset (synchronous, active high) empties the stack and clears the error latch
// a stalled rsp_chan holds the sequencer once result slot and pending are full
module infix_to_postfix_converter_top import i2p_pkg::*; #(
   parameter int STACK_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   i2p_req_if.sink   req_chan,
   i2p_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   state_type state_ff;
   state_type state_in;

   // latched token
   kind_type                tok_kind_ff;
   logic [PAYLOAD_BITS-1:0] tok_payload_ff;
   logic [3:0]              tok_prec_ff;
   logic                    tok_rassoc_ff;

   // first look at the stack for a right parenthesis (empty parens check)
   logic first_ff;
   logic first_in;

   // first error of the current expression
   logic [2:0] err_ff;
   logic [2:0] err_in;

   logic accept;

   stk_ctrl_type            stk_ctrl;
   tag_type                 top_tag;
   logic [PAYLOAD_BITS-1:0] top_payload;
   logic [CW-1:0]           stk_count;
   logic                    stk_full;
   logic                    stk_empty;

   obuf_ctrl_type           ob_ctrl;
   logic [2:0]              item_kind;
   logic [PAYLOAD_BITS-1:0] item_payload;
   logic [2:0]              item_status;
   logic                    slot_ok;
   logic                    pend_valid;

   logic top_is_lparen;
   logic pops_op;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign top_is_lparen  = (top_tag.kind == KIND_LPAREN);

   // shared precedence compare: the stacked operator goes out first if it
   // binds tighter, or equally when the incoming one is left-associative
   assign pops_op = (top_tag.kind == KIND_OP) &&
                    ((top_tag.prec > tok_prec_ff) ||
                     ((top_tag.prec == tok_prec_ff) && !tok_rassoc_ff));

   i2p_stack #(
      .DEPTH        (STACK_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_stack (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (stk_ctrl),
      .wr_tag      ({tok_kind_ff, tok_prec_ff}),
      .wr_payload  (tok_payload_ff),
      .top_tag     (top_tag),
      .top_payload (top_payload),
      .count       (stk_count),
      .full        (stk_full),
      .empty       (stk_empty)
   );

   i2p_outbuf #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_outbuf (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ob_ctrl),
      .item_kind    (item_kind),
      .item_payload (item_payload),
      .item_status  (item_status),
      .slot_ok      (slot_ok),
      .pend_valid   (pend_valid),
      .rsp_chan     (rsp_chan)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (slot_ok) begin
               if (tok_kind_ff == KIND_END) begin
                  state_in = (err_ff != STATUS_OK || stk_empty) ? ST_FINISH : ST_DECIDE;
               end else if (err_ff != STATUS_OK) begin
                  state_in = ST_FINISH;
               end else begin
                  case (tok_kind_ff)
                     KIND_COMMA, KIND_OP, KIND_RPAREN: begin
                        state_in = stk_empty ? ST_FINISH : ST_DECIDE;
                     end
                     default: state_in = ST_FINISH;
                  endcase
               end
            end
         end
         ST_DECIDE: begin
            if (slot_ok) begin
               case (tok_kind_ff)
                  KIND_END, KIND_COMMA: begin
                     state_in = top_is_lparen ? ST_FINISH : ST_DISPATCH;
                  end
                  KIND_OP: begin
                     state_in = pops_op ? ST_DISPATCH : ST_FINISH;
                  end
                  KIND_RPAREN: begin
                     if (!top_is_lparen) begin
                        state_in = ST_DISPATCH;
                     end else if (first_ff || stk_count == CW'(1)) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_FUNC_WAIT;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_FUNC_WAIT: begin
            state_in = ST_FUNC_DECIDE;
         end
         ST_FUNC_DECIDE: begin
            if (slot_ok) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: stack control, result emission, error latch
   always_comb begin
      stk_ctrl     = '0;
      ob_ctrl      = '0;
      item_kind    = out_kind_of(top_tag.kind);
      item_payload = top_payload;
      item_status  = STATUS_OK;
      err_in       = err_ff;
      first_in     = first_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               first_in = 1'b1;
            end
         end
         ST_DISPATCH: begin
            if (slot_ok) begin
               if (tok_kind_ff == KIND_END) begin
                  if (err_ff != STATUS_OK || stk_empty) begin
                     // end marker carries the latched status
                     ob_ctrl.emit   = 1'b1;
                     item_kind      = OUT_KIND_END;
                     item_payload   = '0;
                     item_status    = err_ff;
                     stk_ctrl.clear = 1'b1;
                     err_in         = STATUS_OK;
                  end
               end else if (err_ff == STATUS_OK) begin
                  case (tok_kind_ff)
                     KIND_NUM, KIND_VAR: begin
                        // operands pass straight through
                        ob_ctrl.emit = 1'b1;
                        item_kind    = out_kind_of(tok_kind_ff);
                        item_payload = tok_payload_ff;
                     end
                     KIND_FUNC, KIND_LPAREN: begin
                        if (stk_full) begin
                           err_in = STATUS_OVERFLOW;
                        end else begin
                           stk_ctrl.push = 1'b1;
                        end
                     end
                     KIND_COMMA: begin
                        if (stk_empty) begin
                           err_in = STATUS_COMMA;
                        end
                     end
                     KIND_OP: begin
                        if (stk_empty) begin
                           stk_ctrl.push = 1'b1;
                        end
                     end
                     KIND_RPAREN: begin
                        if (stk_empty) begin
                           err_in = STATUS_MISMATCH;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_DECIDE: begin
            if (slot_ok) begin
               case (tok_kind_ff)
                  KIND_END: begin
                     if (top_is_lparen) begin
                        // unclosed left parenthesis found while flushing
                        ob_ctrl.emit   = 1'b1;
                        item_kind      = OUT_KIND_END;
                        item_payload   = '0;
                        item_status    = STATUS_MISMATCH;
                        stk_ctrl.clear = 1'b1;
                        err_in         = STATUS_OK;
                     end else begin
                        stk_ctrl.pop = 1'b1;
                        ob_ctrl.emit = 1'b1;
                     end
                  end
                  KIND_COMMA: begin
                     if (!top_is_lparen) begin
                        stk_ctrl.pop = 1'b1;
                        ob_ctrl.emit = 1'b1;
                     end
                  end
                  KIND_OP: begin
                     if (pops_op) begin
                        stk_ctrl.pop = 1'b1;
                        ob_ctrl.emit = 1'b1;
                     end else if (stk_full) begin
                        err_in = STATUS_OVERFLOW;
                     end else begin
                        stk_ctrl.push = 1'b1;
                     end
                  end
                  KIND_RPAREN: begin
                     if (!top_is_lparen) begin
                        stk_ctrl.pop = 1'b1;
                        ob_ctrl.emit = 1'b1;
                        first_in     = 1'b0;
                     end else if (first_ff) begin
                        err_in = STATUS_EMPTY;
                     end else begin
                        // drop the matching left parenthesis
                        stk_ctrl.pop = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FUNC_DECIDE: begin
            if (slot_ok && top_tag.kind == KIND_FUNC) begin
               stk_ctrl.pop = 1'b1;
               ob_ctrl.emit = 1'b1;
            end
         end
         ST_FINISH: begin
            ob_ctrl.finish = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff   <= STATUS_OK;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tok_kind_ff    <= kind_type'(req_chan.kind);
         tok_payload_ff <= req_chan.payload;
         tok_prec_ff    <= req_chan.precedence;
         tok_rassoc_ff  <= req_chan.right_assoc;
      end
   end

   // no result of the previous token may still be held back once a new one is taken
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !pend_valid)
      else $error("pending result left behind at idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stk_count <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_status_only_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_kind != OUT_KIND_END) |-> rsp_chan.status == STATUS_OK)
      else $error("status set on a non end token");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_kind == OUT_KIND_END) |-> rsp_chan.last)
      else $error("end marker not flagged last");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && state_in == ST_IDLE && tok_kind_ff == KIND_END)
      |=> (err_ff == STATUS_OK && stk_empty))
      else $error("end token left state behind");

endmodule
